### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off during reset.
`define BFCH_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfch assertion failed");

// Implication checked in the following cycle, off during reset.
`define BFCH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfch assertion failed");

`endif

### design/bfch_pkg.sv
package bfch_pkg;

   // Capacity and coordinate width.
   localparam int MAX_POINTS = 32;
   localparam int COORD_BITS = 12;
   localparam int MIN_POINTS = 3;

   // Derived widths.
   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SIDE_W = PROD_W + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // Input word: one point.
   typedef struct packed {
      coord_type px;
      coord_type py;
      logic      final_point;
   } req_word_type;

   // Output word: one hull point or the no-hull marker.
   typedef struct packed {
      coord_type hull_x;
      coord_type hull_y;
      logic      status;
      logic      dropped;
      logic      end_of_hull;
   } rsp_word_type;

   // Kind of test a token carries down the cell row.
   typedef enum logic [2:0] {
      MODE_FIND = 3'b001,
      MODE_COLL = 3'b010,
      MODE_EDGE = 3'b100
   } mode_type;

   // Side of a point against a line: negative, zero, or neither (positive).
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   // Token that moves along the row, cell by cell.
   typedef struct packed {
      logic             valid;
      mode_type         mode;
      logic [IDX_W-1:0] i_idx;
      logic [IDX_W-1:0] j_idx;
      coord_type        ax;
      coord_type        ay;
      coord_type        bx;
      coord_type        by;
      logic             ok;
      logic             found;
      logic             have_first;
      sign_type         first;
      logic             jflag;
   } token_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             kill;
      logic             clear;
      logic             load;
      logic [IDX_W-1:0] load_idx;
      coord_type        load_x;
      coord_type        load_y;
      logic             mark_a;
      coord_type        mark_ax;
      coord_type        mark_ay;
      logic             mark_b;
      coord_type        mark_bx;
      coord_type        mark_by;
   } bcast_type;

endpackage

### design/bfch_cell.sv
module bfch_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bfch_pkg::IDX_W-1:0]   cell_idx,
   input  bfch_pkg::bcast_type          bcast,
   input  bfch_pkg::token_type          tok_in,
   output bfch_pkg::token_type          tok_out
);

   localparam int DW = bfch_pkg::DIFF_W;
   localparam int PW = bfch_pkg::PROD_W;
   localparam int SW = bfch_pkg::SIDE_W;
   localparam int CW = bfch_pkg::CNT_W;

   bfch_pkg::coord_type px_ff, py_ff;
   logic                flag_ff;
   bfch_pkg::token_type s1_ff, s1_in;
   bfch_pkg::token_type tok_ff, tok_in_next;
   logic signed [PW-1:0] prod1_ff, prod2_ff;
   logic signed [PW-1:0] prod1_in, prod2_in;
   logic signed [DW-1:0] dxb, dyb, dxp, dyp;
   logic signed [SW-1:0] side;
   bfch_pkg::sign_type   sgn;
   logic                 active;
   logic                 hit_a, hit_b;

   // The cell takes part only while its slot holds a loaded point.
   assign active = CW'(cell_idx) < bcast.count;

   // Stored point of this slot.
   always_ff @(posedge clock) begin
      if (bcast.load && bcast.load_idx == cell_idx) begin
         px_ff <= bcast.load_x;
         py_ff <= bcast.load_y;
      end
   end

   // Hull membership, matched by coordinates.
   assign hit_a = bcast.mark_a && px_ff == bcast.mark_ax && py_ff == bcast.mark_ay;
   assign hit_b = bcast.mark_b && px_ff == bcast.mark_bx && py_ff == bcast.mark_by;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else if (bcast.clear) begin
         flag_ff <= 1'b0;
      end else if (active && (hit_a || hit_b)) begin
         flag_ff <= 1'b1;
      end
   end

   // First stage: the two cross-product terms.
   always_comb begin
      dxb      = DW'(tok_in.bx) - DW'(tok_in.ax);
      dyb      = DW'(tok_in.by) - DW'(tok_in.ay);
      dxp      = DW'(px_ff) - DW'(tok_in.ax);
      dyp      = DW'(py_ff) - DW'(tok_in.ay);
      prod1_in = dyp * dxb;
      prod2_in = dyb * dxp;
      s1_in    = tok_in;
      s1_in.valid = tok_in.valid && !bcast.kill;
   end

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      s1_ff.mode       <= s1_in.mode;
      s1_ff.i_idx      <= s1_in.i_idx;
      s1_ff.j_idx      <= s1_in.j_idx;
      s1_ff.ax         <= s1_in.ax;
      s1_ff.ay         <= s1_in.ay;
      s1_ff.bx         <= s1_in.bx;
      s1_ff.by         <= s1_in.by;
      s1_ff.ok         <= s1_in.ok;
      s1_ff.found      <= s1_in.found;
      s1_ff.have_first <= s1_in.have_first;
      s1_ff.first      <= s1_in.first;
      s1_ff.jflag      <= s1_in.jflag;
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
   end

   // Second stage: side sign and the update of the running test.
   always_comb begin
      side     = SW'(prod1_ff) - SW'(prod2_ff);
      sgn.neg  = side[SW-1];
      sgn.zero = (side == '0);
      tok_in_next       = s1_ff;
      tok_in_next.valid = s1_ff.valid && !bcast.kill;
      if (active) begin
         unique case (s1_ff.mode)
            bfch_pkg::MODE_FIND: begin
               if (!s1_ff.found && (px_ff != s1_ff.ax || py_ff != s1_ff.ay)) begin
                  tok_in_next.found = 1'b1;
                  tok_in_next.bx    = px_ff;
                  tok_in_next.by    = py_ff;
               end
            end
            bfch_pkg::MODE_COLL: begin
               if (!sgn.zero) begin
                  tok_in_next.ok = 1'b0;
               end
            end
            bfch_pkg::MODE_EDGE: begin
               if (cell_idx != s1_ff.i_idx && cell_idx != s1_ff.j_idx) begin
                  if (!s1_ff.have_first) begin
                     tok_in_next.have_first = 1'b1;
                     tok_in_next.first      = sgn;
                  end else if (sgn != s1_ff.first) begin
                     tok_in_next.ok = 1'b0;
                  end
               end
               if (cell_idx == s1_ff.j_idx) begin
                  tok_in_next.jflag = flag_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      tok_ff.mode       <= tok_in_next.mode;
      tok_ff.i_idx      <= tok_in_next.i_idx;
      tok_ff.j_idx      <= tok_in_next.j_idx;
      tok_ff.ax         <= tok_in_next.ax;
      tok_ff.ay         <= tok_in_next.ay;
      tok_ff.bx         <= tok_in_next.bx;
      tok_ff.by         <= tok_in_next.by;
      tok_ff.ok         <= tok_in_next.ok;
      tok_ff.found      <= tok_in_next.found;
      tok_ff.have_first <= tok_in_next.have_first;
      tok_ff.first      <= tok_in_next.first;
      tok_ff.jflag      <= tok_in_next.jflag;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
   end

   assign tok_out = tok_ff;

endmodule

### design/brute_force_convex_hull_core.sv
// Loading stores up to MAX_POINTS point words; the final point starts the hull walk.
// Walk: degenerate-set checks, then passes of N loaded points via the two-stage cell row.
// The search for the first hull point takes up to N passes, then one pass per hull point.
// Results leave one word per cycle unless stalled; input waits until all are issued.
// Synchronous reset clears control state; stored points stay undefined until written.
module brute_force_convex_hull_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bfch_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bfch_pkg::rsp_word_type  rsp_word
);

   localparam int NP = bfch_pkg::MAX_POINTS;
   localparam int IW = bfch_pkg::IDX_W;
   localparam int CW = bfch_pkg::CNT_W;

   typedef enum logic [8:0] {
      ST_LOAD  = 9'b000000001,
      ST_START = 9'b000000010,
      ST_FIND  = 9'b000000100,
      ST_FWAIT = 9'b000001000,
      ST_CWAIT = 9'b000010000,
      ST_PASSA = 9'b000100000,
      ST_PASSB = 9'b001000000,
      ST_RUN   = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [IW-1:0] i_ff, i_in;
   logic          have_next_ff, have_next_in;
   logic [CW-1:0] send_ff, send_in;
   logic [CW-1:0] recv_ff, recv_in;
   logic          tag_v_ff, tag_v_in;
   logic [IW-1:0] tag_j_ff, tag_j_in;
   bfch_pkg::coord_type a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic [CW-1:0] hull_len_ff, hull_len_in;
   logic          pend_ff, pend_in;
   bfch_pkg::coord_type pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [CW-1:0] emit_ff, emit_in;

   // Point memory, one copy for issuing line ends.
   bfch_pkg::coord_type pmem_x [NP];
   bfch_pkg::coord_type pmem_y [NP];
   bfch_pkg::coord_type pm_rd_x_ff, pm_rd_y_ff;
   logic [IW-1:0]       pm_addr;
   logic                pm_we;

   // Hull memory, in discovery order.
   bfch_pkg::coord_type hmem_x [NP];
   bfch_pkg::coord_type hmem_y [NP];
   bfch_pkg::coord_type hm_rd_x_ff, hm_rd_y_ff;
   logic                hm_we;
   bfch_pkg::coord_type hm_wx, hm_wy;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic status_ff, dropped_ff, eoh_ff;
   logic rsp_load;

   bfch_pkg::bcast_type bcast;
   bfch_pkg::token_type tok_in;
   bfch_pkg::token_type chain [NP+1];
   bfch_pkg::token_type chain_out;

   logic          req_acc;
   logic          good, inhull, last_res;
   logic [CW-1:0] total;

   // Row of cells, one per point slot.
   assign chain[0]  = tok_in;
   assign chain_out = chain[NP];

   for (genvar g = 0; g < NP; g++) begin : g_cell
      bfch_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IW'(g)),
         .bcast    (bcast),
         .tok_in   (chain[g]),
         .tok_out  (chain[g+1])
      );
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign total     = (hull_len_ff == '0) ? CW'(1) : hull_len_ff;
   assign good      = chain_out.ok && (chain_out.j_idx != chain_out.i_idx);
   assign inhull    = chain_out.jflag ||
                      (chain_out.bx == chain_out.ax && chain_out.by == chain_out.ay);
   assign last_res  = (recv_ff == count_ff - CW'(1));

   // Sequencer: load, degenerate checks, hull passes, emission.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      have_next_in = have_next_ff;
      send_in      = send_ff;
      recv_in      = recv_ff;
      tag_v_in     = 1'b0;
      tag_j_in     = tag_j_ff;
      a_x_in       = a_x_ff;
      a_y_in       = a_y_ff;
      hull_len_in  = hull_len_ff;
      pend_in      = pend_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      emit_in      = emit_ff;
      pm_addr      = '0;
      pm_we        = 1'b0;
      hm_we        = 1'b0;
      hm_wx        = chain_out.ax;
      hm_wy        = chain_out.ay;
      rsp_load     = 1'b0;

      bcast          = '0;
      bcast.count    = count_ff;
      bcast.load_idx = count_ff[IW-1:0];
      bcast.load_x   = req_word.px;
      bcast.load_y   = req_word.py;
      bcast.mark_ax  = chain_out.ax;
      bcast.mark_ay  = chain_out.ay;
      bcast.mark_bx  = chain_out.bx;
      bcast.mark_by  = chain_out.by;

      tok_in            = '0;
      tok_in.mode       = bfch_pkg::MODE_EDGE;
      tok_in.i_idx      = i_ff;
      tok_in.j_idx      = tag_j_ff;
      tok_in.ax         = a_x_ff;
      tok_in.ay         = a_y_ff;
      tok_in.bx         = pm_rd_x_ff;
      tok_in.by         = pm_rd_y_ff;
      tok_in.ok         = 1'b1;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (count_ff < CW'(NP)) begin
                  pm_we      = 1'b1;
                  bcast.load = 1'b1;
                  count_in   = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_word.final_point) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            bcast.clear  = 1'b1;
            hull_len_in  = '0;
            have_next_in = 1'b0;
            pend_in      = 1'b0;
            emit_in      = '0;
            if (count_ff < CW'(bfch_pkg::MIN_POINTS)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            // Look for the first point that differs from point zero.
            a_x_in       = pm_rd_x_ff;
            a_y_in       = pm_rd_y_ff;
            tok_in.valid = 1'b1;
            tok_in.mode  = bfch_pkg::MODE_FIND;
            tok_in.ax    = pm_rd_x_ff;
            tok_in.ay    = pm_rd_y_ff;
            state_in     = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (chain_out.valid) begin
               if (!chain_out.found) begin
                  state_in = ST_EMIT;
               end else begin
                  tok_in.valid = 1'b1;
                  tok_in.mode  = bfch_pkg::MODE_COLL;
                  tok_in.bx    = chain_out.bx;
                  tok_in.by    = chain_out.by;
                  state_in     = ST_CWAIT;
               end
            end
         end
         ST_CWAIT: begin
            if (chain_out.valid) begin
               if (chain_out.ok) begin
                  state_in = ST_EMIT;
               end else begin
                  i_in     = '0;
                  state_in = ST_PASSA;
               end
            end
         end
         ST_PASSA: begin
            pm_addr = i_ff;
            if (pend_ff) begin
               hm_we       = 1'b1;
               hm_wx       = pend_x_ff;
               hm_wy       = pend_y_ff;
               hull_len_in = hull_len_ff + CW'(1);
               pend_in     = 1'b0;
            end
            state_in = ST_PASSB;
         end
         ST_PASSB: begin
            a_x_in   = pm_rd_x_ff;
            a_y_in   = pm_rd_y_ff;
            pm_addr  = '0;
            tag_v_in = 1'b1;
            tag_j_in = '0;
            send_in  = CW'(1);
            recv_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // Stream one candidate end point per cycle.
            tok_in.valid = tag_v_ff;
            if (send_ff < count_ff) begin
               pm_addr  = send_ff[IW-1:0];
               tag_v_in = 1'b1;
               tag_j_in = send_ff[IW-1:0];
               send_in  = send_ff + CW'(1);
            end
            // Judge finished edge tests in issue order.
            if (chain_out.valid) begin
               recv_in = recv_ff + CW'(1);
               if (good && !have_next_ff) begin
                  hm_we        = 1'b1;
                  hull_len_in  = hull_len_ff + CW'(1);
                  bcast.mark_a = 1'b1;
               end
               if (good && !inhull) begin
                  bcast.kill   = 1'b1;
                  bcast.mark_b = 1'b1;
                  tag_v_in     = 1'b0;
                  i_in         = chain_out.j_idx;
                  have_next_in = 1'b1;
                  if (have_next_ff) begin
                     hm_we       = 1'b1;
                     hm_wx       = chain_out.bx;
                     hm_wy       = chain_out.by;
                     hull_len_in = hull_len_ff + CW'(1);
                  end else begin
                     pend_in   = 1'b1;
                     pend_x_in = chain_out.bx;
                     pend_y_in = chain_out.by;
                  end
                  state_in = ST_PASSA;
               end else begin
                  if (good) begin
                     have_next_in = 1'b1;
                  end
                  if (last_res) begin
                     if (have_next_ff || good) begin
                        state_in = ST_EMIT;
                     end else if (CW'(i_ff) == count_ff - CW'(1)) begin
                        state_in = ST_EMIT;
                     end else begin
                        i_in     = i_ff + IW'(1);
                        state_in = ST_PASSA;
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            if (emit_ff == total) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               emit_in  = emit_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         have_next_ff <= 1'b0;
         tag_v_ff     <= 1'b0;
         hull_len_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         have_next_ff <= have_next_in;
         tag_v_ff     <= tag_v_in;
         hull_len_ff  <= hull_len_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Counters and operands.
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      send_ff   <= send_in;
      recv_ff   <= recv_in;
      tag_j_ff  <= tag_j_in;
      a_x_ff    <= a_x_in;
      a_y_ff    <= a_y_in;
      pend_x_ff <= pend_x_in;
      pend_y_ff <= pend_y_in;
      emit_ff   <= emit_in;
   end

   // Point memory: written at load, read one address per cycle.
   always_ff @(posedge clock) begin
      if (pm_we) begin
         pmem_x[count_ff[IW-1:0]] <= req_word.px;
         pmem_y[count_ff[IW-1:0]] <= req_word.py;
      end
      pm_rd_x_ff <= pmem_x[pm_addr];
      pm_rd_y_ff <= pmem_y[pm_addr];
   end

   // Hull memory: appended during the walk, read into the output register.
   always_ff @(posedge clock) begin
      if (hm_we) begin
         hmem_x[hull_len_ff[IW-1:0]] <= hm_wx;
         hmem_y[hull_len_ff[IW-1:0]] <= hm_wy;
      end
      if (rsp_load) begin
         hm_rd_x_ff <= hmem_x[emit_ff[IW-1:0]];
         hm_rd_y_ff <= hmem_y[emit_ff[IW-1:0]];
      end
   end

   // Output word flags.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff  <= (hull_len_ff == '0);
         dropped_ff <= ovf_ff;
         eoh_ff     <= (emit_ff == total - CW'(1));
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_word.hull_x      = status_ff ? '0 : hm_rd_x_ff;
   assign rsp_word.hull_y      = status_ff ? '0 : hm_rd_y_ff;
   assign rsp_word.status      = status_ff;
   assign rsp_word.dropped     = dropped_ff;
   assign rsp_word.end_of_hull = eoh_ff;

endmodule

### design/bfch_checker.sv
`include "assert_macros.svh"

module bfch_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input bfch_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bfch_pkg::rsp_word_type rsp_word
);

   // A stalled result word stays put.
   `BFCH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // Nothing comes out right after reset.
   `BFCH_ASSERT(a_reset_quiet, $past(reset), !rsp_valid)

   // A no-hull word is alone in its run and carries zero coordinates.
   `BFCH_ASSERT(a_nohull_form, rsp_valid && rsp_word.status, rsp_word.end_of_hull && rsp_word.hull_x == '0 && rsp_word.hull_y == '0)

   // The final point starts the walk, so input is held off next cycle.
   `BFCH_ASSERT_NEXT(a_walk_starts, req_valid && !req_stall && req_word.final_point, req_stall)

endmodule

bind brute_force_convex_hull_core bfch_checker u_bfch_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   bfch_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   bfch_pkg::rsp_word_type rsp_word;

   brute_force_convex_hull_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   localparam int IDLE_LIMIT = 60000;
   localparam int HOLD_CYCLES = 3000;

   bfch_pkg::req_word_type point_queue[$];
   bfch_pkg::rsp_word_type hull_expect[$];

   // Predictor copy of the point set.
   longint set_x[bfch_pkg::MAX_POINTS];
   longint set_y[bfch_pkg::MAX_POINTS];
   int     set_count;
   bit     set_overflow;
   bit     on_hull[bfch_pkg::MAX_POINTS];
   int     hull_idx[bfch_pkg::MAX_POINTS];
   int     hull_len;

   int  mismatches;
   int  words_in;
   int  words_out;
   int  sets_done;
   int  overflow_sets;
   int  nohull_sets;
   int  idle_cycles;
   bit  req_taken;

   // Clock and reset.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Sign of the cross product of point p against the line a->b.
   function automatic int side_sign(int a, int b, int p);
      longint v;
      v = (set_y[p] - set_y[a]) * (set_x[b] - set_x[a])
        - (set_y[b] - set_y[a]) * (set_x[p] - set_x[a]);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic bit same_point(int a, int b);
      return set_x[a] == set_x[b] && set_y[a] == set_y[b];
   endfunction

   function automatic bit degenerate_set(int n);
      int d;
      d = 1;
      while (d < n && same_point(0, d)) d++;
      if (d >= n) return 1'b1;
      for (int k = 0; k < n; k++)
         if (side_sign(0, d, k) != 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit hull_edge(int i, int j, int n);
      int  first_side;
      bit  have_first;
      have_first = 1'b0;
      first_side = 0;
      for (int k = 0; k < n; k++) begin
         if (k == i || k == j) continue;
         if (!have_first) begin
            first_side = side_sign(i, j, k);
            have_first = 1'b1;
         end else if (side_sign(i, j, k) != first_side) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Duplicates of a hull point are flagged along with it.
   function automatic void join_hull(int idx, int n);
      if (hull_len >= bfch_pkg::MAX_POINTS) return;
      hull_idx[hull_len] = idx;
      hull_len++;
      for (int k = 0; k < n; k++)
         if (same_point(k, idx)) on_hull[k] = 1'b1;
   endfunction

   function automatic void hull_walk(int n);
      int i, nextp;
      bit have_next, finished, added;
      i = 0;
      nextp = 0;
      have_next = 1'b0;
      finished = 1'b0;
      while (i < n && !finished) begin
         if (hull_len != 0) finished = 1'b1;
         added = 1'b0;
         if (have_next) i = nextp;
         for (int j = 0; j < n && !added; j++) begin
            if (j == i || !hull_edge(i, j, n)) continue;
            if (!have_next) join_hull(i, n);
            added = 1'b1;
            finished = 1'b0;
            if (on_hull[j]) begin
               added = 1'b0;
               finished = 1'b1;
            end
            if (added) join_hull(j, n);
            nextp = j;
            have_next = 1'b1;
         end
         if (!have_next) i++;
      end
   endfunction

   // Store one accepted point; a final point queues the expected hull words.
   function automatic void predict_hull(bfch_pkg::req_word_type w);
      bfch_pkg::rsp_word_type r;
      if (set_count < bfch_pkg::MAX_POINTS) begin
         set_x[set_count] = longint'(w.px);
         set_y[set_count] = longint'(w.py);
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (!w.final_point) return;
      hull_len = 0;
      for (int k = 0; k < bfch_pkg::MAX_POINTS; k++) on_hull[k] = 1'b0;
      if (set_count >= bfch_pkg::MIN_POINTS && !degenerate_set(set_count))
         hull_walk(set_count);
      if (hull_len == 0) begin
         r = '0;
         r.status = 1'b1;
         r.dropped = set_overflow;
         r.end_of_hull = 1'b1;
         hull_expect.insert(hull_expect.size(), r);
         nohull_sets++;
      end else begin
         for (int h = 0; h < hull_len; h++) begin
            r.hull_x = bfch_pkg::coord_type'(set_x[hull_idx[h]]);
            r.hull_y = bfch_pkg::coord_type'(set_y[hull_idx[h]]);
            r.status = 1'b0;
            r.dropped = set_overflow;
            r.end_of_hull = (h == hull_len - 1);
            hull_expect.insert(hull_expect.size(), r);
         end
      end
      if (set_overflow) overflow_sets++;
      sets_done++;
      set_count = 0;
      set_overflow = 1'b0;
   endfunction

   task automatic add_point(int x, int y, bit last);
      bfch_pkg::req_word_type w;
      w.px = bfch_pkg::coord_type'(x);
      w.py = bfch_pkg::coord_type'(y);
      w.final_point = last;
      point_queue.insert(point_queue.size(), w);
   endtask

   // A set of n points drawn from [-span, span-1], the last one final.
   task automatic add_random_set(int n, int span);
      for (int k = 0; k < n; k++)
         add_point($urandom_range(0, 2 * span - 1) - span,
                   $urandom_range(0, 2 * span - 1) - span, k == n - 1);
   endtask

   // Stimulus: directed corner sets, then random sets.
   initial begin
      int n, pick, span;
      // Single point and two points: too few for a hull.
      add_point(5, 5, 1);
      add_point(0, 0, 0); add_point(1, 1, 1);
      // Collinear along the diagonal, at the coordinate extremes.
      add_point(-2048, -2048, 0); add_point(0, 0, 0); add_point(2047, 2047, 1);
      // Extreme triangle.
      add_point(-2048, -2048, 0); add_point(2047, -2048, 0); add_point(-2048, 2047, 1);
      // Square with a duplicate corner and an interior point.
      add_point(0, 0, 0); add_point(100, 0, 0); add_point(100, 0, 0);
      add_point(100, 100, 0); add_point(0, 100, 0); add_point(50, 50, 1);
      // All points identical.
      add_point(7, -7, 0); add_point(7, -7, 0); add_point(7, -7, 1);
      // Full-range corners around the origin.
      add_point(2047, 2047, 0); add_point(-2048, 2047, 0); add_point(2047, -2048, 0);
      add_point(-2048, -2048, 0); add_point(0, 0, 1);
      // Random sets, mostly small, a few that overflow the store.
      while (point_queue.size() < 310) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) n = $urandom_range(1, 2);
         else if (pick < 8)
            n = $urandom_range(bfch_pkg::MAX_POINTS + 1, bfch_pkg::MAX_POINTS + 3);
         else if (pick < 15) n = $urandom_range(11, 20);
         else n = $urandom_range(3, 10);
         span = ($urandom_range(0, 99) < 30) ? 2 : 2048;
         add_random_set(n, span);
      end
   end

   // Input driver: bursts of words with random gaps.
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
         burst_left = 10;
         gap_left = 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (point_queue.size() > 0) begin
            req_word <= point_queue.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off during the run.
   int  stall_pct;
   int  phase_left;
   int  hold_left;
   bit  hold_done;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_pct = 0;
         phase_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (!hold_done && words_in >= 150) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0, 1: stall_pct = 0;
               2: stall_pct = 30;
               default: stall_pct = 75;
            endcase
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Monitor: predict on accepted points, check accepted hull words.
   always @(posedge clock) begin
      bfch_pkg::rsp_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall) begin
            words_in++;
            predict_hull(req_word);
         end
         if (rsp_valid && !rsp_stall) begin
            words_out++;
            if (hull_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected hull word: x=%0d y=%0d st=%0b drop=%0b end=%0b",
                           rsp_word.hull_x, rsp_word.hull_y, rsp_word.status,
                           rsp_word.dropped, rsp_word.end_of_hull);
            end else begin
               want = hull_expect.pop_front();
               if (rsp_word !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Hull word %0d mismatch: expected x=%0d y=%0d st=%0b ",
                               "drop=%0b end=%0b, got x=%0d y=%0d st=%0b drop=%0b end=%0b"},
                              words_out, want.hull_x, want.hull_y, want.status,
                              want.dropped, want.end_of_hull, rsp_word.hull_x,
                              rsp_word.hull_y, rsp_word.status, rsp_word.dropped,
                              rsp_word.end_of_hull);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word on either side.
   always @(posedge clock) begin
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no word accepted for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // End of run.
   initial begin
      mismatches = 0;
      words_in = 0;
      words_out = 0;
      sets_done = 0;
      overflow_sets = 0;
      nohull_sets = 0;
      set_count = 0;
      set_overflow = 1'b0;
      @(negedge reset);
      repeat (5) @(posedge clock);
      while (point_queue.size() > 0 || req_valid) @(posedge clock);
      while (hull_expect.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (hull_expect.size() > 0) mismatches++;
      $display("Ran %0d points in %0d sets (%0d without a hull, %0d over capacity).",
               words_in, sets_done, nohull_sets, overflow_sets);
      $display("Checked %0d hull words, %0d mismatches.", words_out, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
